@@ src/agas_pkg.sv @@
// ----------------------------------------------------------------------------
// agas_pkg: shared types, constants and score helpers
// Score arithmetic saturates into [MINUS_INF, SCORE_TOP].
// ----------------------------------------------------------------------------
package agas_pkg;

    localparam int MAX_H = 256;
    localparam int CNT_W = $clog2(MAX_H + 1);
    localparam int IDX_W = (MAX_H > 1) ? $clog2(MAX_H) : 1;

    typedef logic signed [31:0] t_score;
    typedef logic signed [7:0]  t_wt;

    localparam t_score MINUS_INF = -32'sd536870912;
    localparam t_score SCORE_TOP = 32'sd2147483647;
    localparam logic signed [32:0] SUM_LO = -33'sd536870912;
    localparam logic signed [32:0] SUM_HI = 33'sd2147483647;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_VERT   = 2'd1,
        REQ_FINISH = 2'd2
    } t_req;

    localparam logic [2:0] CFG_MATCH    = 3'd0;
    localparam logic [2:0] CFG_MISMATCH = 3'd1;
    localparam logic [2:0] CFG_GAP_OPEN = 3'd2;
    localparam logic [2:0] CFG_GAP_EXT  = 3'd3;
    localparam logic [2:0] CFG_MODE     = 3'd4;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_DOWN  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;
    localparam logic [1:0] MODE_ANY   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_LATE     = 2'd2;

    typedef enum logic [1:0] {
        OP_ADV  = 2'd0,
        OP_CLR  = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_COL0 = 2'd1,
        S_RUN  = 2'd2
    } t_state;

    // row controls broadcast to every cell during one pass
    typedef struct packed {
        t_op        op;
        logic       first_row;
        logic       use_d;
        logic       use_r;
        logic       use_dn;
        logic       allow_down;
        logic [7:0] vsym;
        t_wt        m;
        t_wt        x;
        t_wt        g;
        t_wt        e;
    } t_row_ctl;

    // wavefront token handed from one column to the next
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] rem;
        t_score           old_d;
        t_score           old_r;
        t_score           old_dn;
        t_score           new_d;
        t_score           new_r;
        t_score           new_dn;
    } t_link;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [7:0]       sym;
    } t_load;

    function automatic t_score sat_add(input t_score a, input t_wt b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({{25{b[7]}}, b});
        if (s < SUM_LO) begin
            return MINUS_INF;
        end else if (s > SUM_HI) begin
            return SCORE_TOP;
        end else begin
            return s[31:0];
        end
    endfunction

    function automatic t_score smax(input t_score a, input t_score b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ src/agas_cell.sv @@
// ----------------------------------------------------------------------------
// agas_cell: one column of the score rows
// Holds one horizontal symbol and the three scores of its column, updates
// them when the wavefront token passes and hands the token on.
// ----------------------------------------------------------------------------
module agas_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  agas_pkg::t_row_ctl i_ctl,
    input  logic               i_load_we,
    input  logic [7:0]         i_load_sym,
    input  agas_pkg::t_link    i_link,
    output agas_pkg::t_link    o_link
);

    logic [7:0]       r_sym;
    agas_pkg::t_score r_d, r_r, r_dn;
    agas_pkg::t_score n_d, n_r, n_dn;
    agas_pkg::t_link  r_link, n_link;

    agas_pkg::t_score fr_r, od, orr, odn, best, nd, nr, ndn;
    logic             act;

    always_comb begin
        // first matrix row, rebuilt on the fly from the left neighbor
        fr_r = agas_pkg::smax(agas_pkg::sat_add(i_link.old_d, i_ctl.g),
                              agas_pkg::sat_add(i_link.old_r, i_ctl.e));
        od   = i_ctl.first_row ? agas_pkg::MINUS_INF : r_d;
        orr  = i_ctl.first_row ? fr_r : r_r;
        odn  = i_ctl.first_row ? agas_pkg::MINUS_INF : r_dn;

        best = agas_pkg::MINUS_INF;
        if (i_ctl.use_d) begin
            best = agas_pkg::smax(best, i_link.old_d);
        end
        if (i_ctl.use_r) begin
            best = agas_pkg::smax(best, i_link.old_r);
        end
        if (i_ctl.use_dn) begin
            best = agas_pkg::smax(best, i_link.old_dn);
        end
        nd  = agas_pkg::sat_add(best, (r_sym == i_ctl.vsym) ? i_ctl.m : i_ctl.x);
        ndn = i_ctl.allow_down ?
              agas_pkg::smax(agas_pkg::sat_add(od, i_ctl.g),
                             agas_pkg::sat_add(odn, i_ctl.e)) :
              agas_pkg::MINUS_INF;
        nr  = agas_pkg::smax(agas_pkg::sat_add(i_link.new_d, i_ctl.g),
                             agas_pkg::sat_add(i_link.new_r, i_ctl.e));

        act    = i_link.valid && (i_link.rem != '0);
        n_link = i_link;
        n_d    = r_d;
        n_r    = r_r;
        n_dn   = r_dn;
        if (act) begin
            n_link.rem    = i_link.rem - 1'b1;
            n_link.old_d  = od;
            n_link.old_r  = orr;
            n_link.old_dn = odn;
            case (i_ctl.op)
                agas_pkg::OP_ADV: begin
                    n_link.new_d  = nd;
                    n_link.new_r  = nr;
                    n_link.new_dn = ndn;
                    n_d  = nd;
                    n_r  = nr;
                    n_dn = ndn;
                end
                agas_pkg::OP_CLR: begin
                    n_link.new_d  = agas_pkg::MINUS_INF;
                    n_link.new_r  = agas_pkg::MINUS_INF;
                    n_link.new_dn = agas_pkg::MINUS_INF;
                    n_d  = agas_pkg::MINUS_INF;
                    n_r  = agas_pkg::MINUS_INF;
                    n_dn = agas_pkg::MINUS_INF;
                end
                agas_pkg::OP_READ: begin
                    n_link.new_d  = od;
                    n_link.new_r  = orr;
                    n_link.new_dn = odn;
                end
                default: begin
                    n_link = i_link;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_d  <= n_d;
        r_r  <= n_r;
        r_dn <= n_dn;
        if (i_load_we) begin
            r_sym <= i_load_sym;
        end
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

@@ src/agas_ctrl.sv @@
// ----------------------------------------------------------------------------
// agas_ctrl: request sequencer, settings and column zero
// Takes requests, keeps counts and error state, starts each wavefront pass
// and forms the score from the token leaving the end of the chain.
// ----------------------------------------------------------------------------
module agas_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [1:0]             i_req_type,
    input  logic [7:0]             i_symbol,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    input  agas_pkg::t_link        i_link_last,
    output logic                   o_busy,
    output logic                   o_strobe,
    output logic signed [31:0]     o_score,
    output logic [1:0]             o_status,
    output agas_pkg::t_row_ctl     o_ctl,
    output agas_pkg::t_link        o_link0,
    output agas_pkg::t_load        o_load
);

    agas_pkg::t_state r_state, n_state;
    agas_pkg::t_wt    r_m, r_x, r_g, r_e;
    logic [1:0]       r_mode;
    logic [agas_pkg::CNT_W-1:0] r_count, n_count;
    logic [agas_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_rows, n_rows;
    logic [1:0]       r_err, n_err;
    agas_pkg::t_score r_dn0, n_dn0;
    agas_pkg::t_row_ctl r_ctl, n_ctl;
    agas_pkg::t_link  r_link0, n_link0;
    logic             r_out_valid, n_out_valid;
    agas_pkg::t_score r_score, n_score;
    logic [1:0]       r_status, n_status;
    agas_pkg::t_load  n_load;

    agas_pkg::t_score pd, pdn, dn_new;
    logic             first;

    // settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m    <= 8'sd1;
            r_x    <= -8'sd1;
            r_g    <= -8'sd2;
            r_e    <= -8'sd1;
            r_mode <= agas_pkg::MODE_ANY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                agas_pkg::CFG_MATCH:    r_m    <= i_cfg_data;
                agas_pkg::CFG_MISMATCH: r_x    <= i_cfg_data;
                agas_pkg::CFG_GAP_OPEN: r_g    <= i_cfg_data;
                agas_pkg::CFG_GAP_EXT:  r_e    <= i_cfg_data;
                agas_pkg::CFG_MODE:     r_mode <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cnt       = r_cnt;
        n_rows      = r_rows;
        n_err       = r_err;
        n_dn0       = r_dn0;
        n_ctl       = r_ctl;
        n_out_valid = 1'b0;
        n_score     = r_score;
        n_status    = r_status;
        n_load      = '{we: 1'b0, idx: r_count[agas_pkg::IDX_W-1:0], sym: i_symbol};
        first       = (r_rows == '0);

        // column zero before this row
        pd     = r_ctl.first_row ? 32'sd0 : agas_pkg::MINUS_INF;
        pdn    = r_ctl.first_row ? agas_pkg::MINUS_INF : r_dn0;
        dn_new = r_ctl.allow_down ?
                 agas_pkg::smax(agas_pkg::sat_add(pd, r_ctl.g),
                                agas_pkg::sat_add(pdn, r_ctl.e)) :
                 agas_pkg::MINUS_INF;

        n_link0        = r_link0;
        n_link0.valid  = 1'b0;
        n_link0.rem    = r_count;
        n_link0.old_d  = pd;
        n_link0.old_r  = agas_pkg::MINUS_INF;
        n_link0.old_dn = pdn;
        n_link0.new_d  = agas_pkg::MINUS_INF;
        n_link0.new_r  = agas_pkg::MINUS_INF;
        n_link0.new_dn = agas_pkg::MINUS_INF;

        case (r_state)
            agas_pkg::S_IDLE: begin
                if (i_start) begin
                    n_ctl.first_row  = first;
                    n_ctl.use_d      = 1'b1;
                    n_ctl.use_r      = 1'b1;
                    n_ctl.use_dn     = 1'b1;
                    n_ctl.allow_down = 1'b1;
                    n_ctl.vsym       = i_symbol;
                    n_ctl.m          = r_m;
                    n_ctl.x          = r_x;
                    n_ctl.g          = r_g;
                    n_ctl.e          = r_e;
                    n_ctl.op         = agas_pkg::OP_READ;
                    case (i_req_type)
                        agas_pkg::REQ_LOAD: begin
                            n_ctl = r_ctl;
                            if (!first) begin
                                if (r_err == agas_pkg::ST_OK) begin
                                    n_err = agas_pkg::ST_LATE;
                                end
                            end else if (r_count == agas_pkg::CNT_W'(agas_pkg::MAX_H)) begin
                                if (r_err == agas_pkg::ST_OK) begin
                                    n_err = agas_pkg::ST_OVERFLOW;
                                end
                            end else begin
                                n_load.we = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        agas_pkg::REQ_VERT: begin
                            n_state   = agas_pkg::S_COL0;
                            n_ctl.op  = agas_pkg::OP_ADV;
                            if (first) begin
                                case (r_mode)
                                    agas_pkg::MODE_NONE: begin
                                        n_ctl.use_r      = 1'b0;
                                        n_ctl.use_dn     = 1'b0;
                                        n_ctl.allow_down = 1'b0;
                                    end
                                    agas_pkg::MODE_DOWN: begin
                                        n_ctl.op = agas_pkg::OP_CLR;
                                    end
                                    agas_pkg::MODE_RIGHT: begin
                                        n_ctl.use_d      = 1'b0;
                                        n_ctl.use_dn     = 1'b0;
                                        n_ctl.allow_down = 1'b0;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        agas_pkg::REQ_FINISH: begin
                            n_state = agas_pkg::S_COL0;
                        end
                        default: begin
                            n_ctl = r_ctl;
                        end
                    endcase
                end
            end
            agas_pkg::S_COL0: begin
                n_link0.valid = 1'b1;
                n_state       = agas_pkg::S_RUN;
                n_cnt         = r_count;
                case (r_ctl.op)
                    agas_pkg::OP_ADV: begin
                        n_link0.new_dn = dn_new;
                        n_dn0          = dn_new;
                        n_rows         = (r_rows != '1) ? r_rows + 32'd1 : r_rows;
                    end
                    agas_pkg::OP_CLR: begin
                        n_dn0  = 32'(r_ctl.g);
                        n_rows = 32'd1;
                    end
                    agas_pkg::OP_READ: begin
                        // wait for the token to clear the whole chain
                        n_link0.new_d  = pd;
                        n_link0.new_dn = pdn;
                        n_cnt          = agas_pkg::CNT_W'(agas_pkg::MAX_H);
                    end
                    default: begin
                    end
                endcase
            end
            agas_pkg::S_RUN: begin
                if (r_cnt == '0) begin
                    n_state = agas_pkg::S_IDLE;
                    if (r_ctl.op == agas_pkg::OP_READ) begin
                        n_out_valid = 1'b1;
                        n_score  = agas_pkg::smax(i_link_last.new_d,
                                       agas_pkg::smax(i_link_last.new_r,
                                                      i_link_last.new_dn));
                        n_status = r_err;
                        n_count  = '0;
                        n_rows   = '0;
                        n_err    = agas_pkg::ST_OK;
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = agas_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= agas_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rows      <= '0;
            r_err       <= agas_pkg::ST_OK;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_count     <= n_count;
            r_rows      <= n_rows;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dn0    <= n_dn0;
        r_ctl    <= n_ctl;
        r_score  <= n_score;
        r_status <= n_status;
        if (!i_rst_n) begin
            r_link0 <= '0;
        end else begin
            r_link0 <= n_link0;
        end
    end

    assign o_busy   = (r_state != agas_pkg::S_IDLE);
    assign o_strobe = r_out_valid;
    assign o_score  = r_score;
    assign o_status = r_status;
    assign o_ctl    = r_ctl;
    assign o_link0  = r_link0;
    assign o_load   = n_load;

endmodule

@@ src/affine_gap_global_align_score.sv @@
// ----------------------------------------------------------------------------
// affine_gap_global_align_score: global alignment score with affine gaps
// Row of column cells keeping the match, right-gap and down-gap scores.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/i_req_type/i_symbol and are taken when start is
//   high and busy is low. Load requests (horizontal symbols) finish in the
//   cycle they are taken; busy stays low. A vertical request sends a token
//   across the column cells, one column per cycle, and busy stays high until
//   the token has passed the columns of the loaded symbols; the next request
//   can be taken once busy is low again. A finish request waits for the token to
//   leave the whole chain of 256 cells: o_strobe pulses for one cycle with
//   o_score and o_status once it has, and the block is cleared for the next
//   pair of sequences.
//   Settings are written through i_cfg_we/i_cfg_idx/i_cfg_data, one per
//   cycle, while busy is low; they apply from the next row.
//   Reset (synchronous, i_rst_n low) restores default settings and clears
//   the symbol count, row count and error state; the score rows need no
//   clearing since the first row is rebuilt on the first vertical symbol.
//   The result port has no back pressure; the receiver must take the strobe.
// ----------------------------------------------------------------------------
module affine_gap_global_align_score (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_symbol,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    output logic               o_strobe,
    output logic signed [31:0] o_score,
    output logic [1:0]         o_status
);

    agas_pkg::t_link    w_link [0:agas_pkg::MAX_H];
    agas_pkg::t_row_ctl w_ctl;
    agas_pkg::t_load    w_load;

    agas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req_type),
        .i_symbol    (i_symbol),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_link_last (w_link[agas_pkg::MAX_H]),
        .o_busy      (busy),
        .o_strobe    (o_strobe),
        .o_score     (o_score),
        .o_status    (o_status),
        .o_ctl       (w_ctl),
        .o_link0     (w_link[0]),
        .o_load      (w_load)
    );

    for (genvar k = 1; k <= agas_pkg::MAX_H; k++) begin : g_cell
        agas_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_we  (w_load.we && (w_load.idx == agas_pkg::IDX_W'(k - 1))),
            .i_load_sym (w_load.sym),
            .i_link     (w_link[k-1]),
            .o_link     (w_link[k])
        );
    end

    // result never appears while a pass is still running
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // a result only follows a pass
    a_strobe_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a pass");

    // scores never fall below the saturation floor
    a_score_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_score >= agas_pkg::MINUS_INF))
        else $error("score below minus infinity");

    // symbol loads never raise busy
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == agas_pkg::REQ_LOAD)) |=> !busy)
        else $error("load request raised busy");

endmodule
